[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on aclk, disabled while aresetn is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// concurrent assertion on aclk that also holds during reset
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/lcs_pkg.sv]
// shared constants and types of the linear contrast stretch block
`default_nettype none

package lcs_pkg;

    // image store geometry
    localparam int MAX_PIXELS = 4096;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W      = IDX_W + 1;

    // field widths
    localparam int PIX_W      = 8;
    localparam int RIDX_W     = 12;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 8;

    // grey value limits
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // request kinds on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // status codes on m_tuser
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // divider: numerator 2*(p-lo)*255 + d, quotient fits in a pixel
    localparam int NUM_W     = 18;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // one classified read waiting for the back end
    typedef struct packed {
        logic             err;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
    } entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic can_push;
        logic has_data;
    } qstat_t;

endpackage

`default_nettype wire

[design/lcs_front.sv]
// front end: accepts words, stores the image, tracks min/max, classifies reads
`default_nettype none

module lcs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcs_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    output logic                          push,
    output lcs_pkg::entry_t               push_entry,
    input  lcs_pkg::qstat_t               qstat
);
    import lcs_pkg::*;

    logic [PIX_W-1:0] mem [MAX_PIXELS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;
    logic             complete_reg, complete_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_err_reg, pend_err_next;
    logic [PIX_W-1:0] pend_lo_reg, pend_lo_next;
    logic [PIX_W-1:0] pend_hi_reg, pend_hi_next;
    logic [PIX_W-1:0] rd_data_reg;

    logic              accept, load_acc, read_acc, wr_en;
    logic [PIX_W-1:0]  pix;
    logic [RIDX_W-1:0] idx;
    logic [CNT_W-1:0]  base_count;
    logic [PIX_W-1:0]  base_min, base_max;

    // handshake: one read may wait here for a queue slot
    assign s_tready = !pend_valid_reg || qstat.can_push;
    assign push     = pend_valid_reg && qstat.can_push;
    assign accept   = s_tvalid && s_tready;
    assign load_acc = accept && (s_tuser == REQ_LOAD);
    assign read_acc = accept && (s_tuser == REQ_READ);
    assign pix      = s_tdata[PIX_W-1:0];
    assign idx      = s_tdata[PIX_W+RIDX_W-1:PIX_W];

    // a load after a complete image starts a new one
    always_comb begin
        base_count = complete_reg ? '0 : count_reg;
        base_min   = complete_reg ? PIX_MAX : min_reg;
        base_max   = complete_reg ? PIX_MIN : max_reg;
        wr_en      = load_acc && (base_count < CNT_W'(MAX_PIXELS));
    end

    // image state update
    always_comb begin
        count_next    = count_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        complete_next = complete_reg;
        if (load_acc) begin
            count_next    = base_count;
            min_next      = base_min;
            max_next      = base_max;
            complete_next = s_tlast;
            if (wr_en) begin
                count_next = base_count + CNT_W'(1);
                if (pix < base_min) begin
                    min_next = pix;
                end
                if (pix > base_max) begin
                    max_next = pix;
                end
            end
        end
    end

    // read classification against the current image
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_err_next   = pend_err_reg;
        pend_lo_next    = pend_lo_reg;
        pend_hi_next    = pend_hi_reg;
        if (read_acc) begin
            pend_valid_next = 1'b1;
            pend_err_next   = !complete_reg || ({1'b0, idx} >= count_reg);
            pend_lo_next    = min_reg;
            pend_hi_next    = max_reg;
        end else if (push) begin
            pend_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            min_reg        <= PIX_MAX;
            max_reg        <= PIX_MIN;
            complete_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            complete_reg   <= complete_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // pending read payload
    always_ff @(posedge aclk) begin
        pend_err_reg <= pend_err_next;
        pend_lo_reg  <= pend_lo_next;
        pend_hi_reg  <= pend_hi_next;
    end

    // pixel store, one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[base_count[IDX_W-1:0]] <= pix;
        end
        if (read_acc) begin
            rd_data_reg <= mem[idx[IDX_W-1:0]];
        end
    end

    // entry handed to the queue
    always_comb begin
        push_entry.err = pend_err_reg;
        push_entry.pix = rd_data_reg;
        push_entry.lo  = pend_lo_reg;
        push_entry.hi  = pend_hi_reg;
    end

endmodule

`default_nettype wire

[design/lcs_queue.sv]
// short fifo of classified reads between front and back
`default_nettype none

module lcs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lcs_pkg::entry_t push_entry,
    input  logic            pop,
    output lcs_pkg::entry_t pop_entry,
    output lcs_pkg::qstat_t qstat
);
    import lcs_pkg::*;

    entry_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    // status and head entry
    assign qstat.can_push = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign qstat.has_data = (cnt_reg != '0);
    assign pop_entry      = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

[design/lcs_back.sv]
// back end: stretches one pixel at a time, dividing bit-serially where needed, and drives the result word
`default_nettype none

module lcs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lcs_pkg::qstat_t               qstat,
    input  lcs_pkg::entry_t               pop_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcs_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import lcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    dsh_reg, dsh_next;
    logic [PIX_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PIX_W-1:0]    res_reg, res_next;
    logic                res_err_reg, res_err_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;

    logic               out_free, fits;
    logic [PIX_W-1:0]   d, diff;
    logic [2*PIX_W-1:0] num;
    logic [PIX_W-1:0]   quo_step;

    assign pop      = (state_reg == ST_IDLE) && qstat.has_data;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // setup arithmetic and one divider step
    always_comb begin
        d        = pop_entry.hi - pop_entry.lo;
        diff     = pop_entry.pix - pop_entry.lo;
        num      = diff * PIX_MAX;
        fits     = (rem_reg >= dsh_reg);
        quo_step = {quo_reg[PIX_W-2:0], fits};
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    res_err_next = STATUS_OK;
                    state_next   = ST_DONE;
                    if (pop_entry.err) begin
                        res_next     = PIX_MIN;
                        res_err_next = STATUS_ERR;
                    end else if (pop_entry.hi <= pop_entry.lo) begin
                        res_next = pop_entry.pix;
                    end else if (pop_entry.pix <= pop_entry.lo) begin
                        res_next = PIX_MIN;
                    end else if (pop_entry.pix >= pop_entry.hi) begin
                        res_next = PIX_MAX;
                    end else begin
                        // numerator 2*num + d over divisor 2*d, aligned to the top quotient bit
                        rem_next   = {1'b0, num, 1'b0} + NUM_W'(d);
                        dsh_next   = NUM_W'({d, 1'b0}) << (DIV_STEPS - 1);
                        quo_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                quo_next  = quo_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    res_next   = quo_step;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_DATA_W'(res_reg);
                    out_user_next  = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        res_reg      <= res_next;
        res_err_reg  <= res_err_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

`default_nettype wire

[design/linear_contrast_stretch.sv]
// Min-max linear contrast stretch of an 8-bit grey image of up to 4096 pixels.
// Load words (s_tuser 0) store pixels in order and track the smallest and
// largest value; the word with s_tlast set completes the image, and the next
// load starts a new one. Loads may follow back to back. Read words (s_tuser 1)
// return one pixel stretched as round((p-min)*255/(max-min)), halves rounded up,
// or the raw pixel when the image is flat; a read before a complete image or
// past its end returns status 1 with data 0. The front end reads the pixel
// store and classifies the read into a registered entry, then a two-entry queue
// passes it to the back end, which sends a read that needs no division straight
// to its result state and runs one that does through setup, eight steps of the
// bit-serial divider and the result, and takes no new read until the last one
// has gone into the output register.
`default_nettype none

module linear_contrast_stretch (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcs_pkg::S_DATA_W-1:0]  s_tdata,   // pixel_in[7:0], read_index[19:8]
    input  logic                          s_tlast,   // last_pixel
    input  logic                          s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcs_pkg::M_DATA_W-1:0]  m_tdata,   // pixel_out[7:0]
    output logic                          m_tuser    // status
);
    import lcs_pkg::*;

    logic   push, pop;
    entry_t push_entry, pop_entry;
    qstat_t qstat;

    // accept, store and classify
    lcs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat)
    );

    // decoupling queue
    lcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    // stretch and output
    lcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[design/lcs_checker.sv]
// port-level checker for the contrast stretch block and its bind
`default_nettype none
`include "assert_macros.svh"

module lcs_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lcs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser
);
    import lcs_pkg::*;

    // a stalled result word stays offered
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")

    // a stalled result word keeps its payload
    `ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result payload changed while stalled")

    // an error word carries zero data
    `ASSERT_CLK(a_err_zero, m_tvalid && (m_tuser == STATUS_ERR) |-> (m_tdata == PIX_MIN), "error word with nonzero data")

    // reset leaves no result word behind
    `ASSERT_CLK_RST(a_rst_idle, !aresetn |=> !m_tvalid, "result word offered after reset")

endmodule

bind linear_contrast_stretch lcs_checker u_lcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[dv/linear_contrast_stretch_test.sv]
// self-checking testbench for the linear contrast stretch block
`timescale 1ns / 1ps

module linear_contrast_stretch_test;
    import lcs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 24;

    // one expected result word
    typedef struct {
        logic [PIX_W-1:0] grey;
        logic             status;
    } stretch_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // pixel_in[7:0], read_index[19:8]
    logic                  s_tlast  = 1'b0; // last_pixel
    logic                  s_tuser  = 1'b0; // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // pixel_out[7:0]
    logic                  m_tuser;         // status

    // predicted image state
    logic [PIX_W-1:0]      grey_store [MAX_PIXELS];
    int unsigned           stored_count = 0;
    logic [PIX_W-1:0]      img_lo       = PIX_MAX;
    logic [PIX_W-1:0]      img_hi       = PIX_MIN;
    bit                    img_done     = 1'b0;

    stretch_result_t       stretched_due [$];
    int unsigned           mismatches     = 0;
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           quiet_cycles   = 0;

    linear_contrast_stretch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // min-max stretch with halves rounded up, flat image passes through
    function automatic logic [PIX_W-1:0] stretch_grey(input logic [PIX_W-1:0] grey);
        int unsigned span, scaled, rounded;
        if (img_hi <= img_lo) return grey;
        if (grey <= img_lo) return PIX_MIN;
        if (grey >= img_hi) return PIX_MAX;
        span    = int'(img_hi) - int'(img_lo);
        scaled  = (int'(grey) - int'(img_lo)) * 255;
        rounded = (2 * scaled + span) / (2 * span);
        if (rounded > 255) rounded = 255;
        return rounded[PIX_W-1:0];
    endfunction

    // update the image state for one accepted word, queue any read result
    function automatic void predict_word(input logic req, input logic [PIX_W-1:0] grey,
                                         input logic last, input logic [RIDX_W-1:0] idx);
        stretch_result_t res;
        if (req == REQ_LOAD) begin
            if (img_done) begin
                stored_count = 0;
                img_lo       = PIX_MAX;
                img_hi       = PIX_MIN;
                img_done     = 1'b0;
            end
            if (stored_count < MAX_PIXELS) begin
                grey_store[stored_count] = grey;
                stored_count++;
                if (grey < img_lo) img_lo = grey;
                if (grey > img_hi) img_hi = grey;
            end
            if (last) img_done = 1'b1;
        end else begin
            if (!img_done || idx >= stored_count) begin
                res.grey   = PIX_MIN;
                res.status = STATUS_ERR;
            end else begin
                res.grey   = stretch_grey(grey_store[idx]);
                res.status = STATUS_OK;
            end
            stretched_due.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns mismatch: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // drive one word and wait for it to be taken
    task automatic send_word(input logic req, input logic [PIX_W-1:0] grey,
                             input logic last, input logic [RIDX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, idx, grey};
        s_tlast  <= last;
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(req, grey, last, idx);
    endtask

    // unused fields carry random values, the block must ignore them
    task automatic load_pixel(input logic [PIX_W-1:0] grey, input logic last);
        send_word(REQ_LOAD, grey, last, RIDX_W'($urandom_range(4095)));
    endtask

    task automatic read_pixel(input logic [RIDX_W-1:0] idx);
        send_word(REQ_READ, PIX_W'($urandom()), 1'($urandom()), idx);
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (stretched_due.size() != 0);
    endtask

    // reads before any image exists and while the first is still loading
    task automatic test_early_reads();
        read_pixel(RIDX_W'(0));
        read_pixel(RIDX_W'(4095));
        load_pixel(PIX_MIN, 1'b0);
        load_pixel(PIX_MAX, 1'b0);
        read_pixel(RIDX_W'(0));
        load_pixel(8'd128, 1'b0);
        load_pixel(8'd1, 1'b0);
        load_pixel(8'd254, 1'b1);
    endtask

    // full-range image: ends map to 0 and 255, plus reads past the end
    task automatic test_extreme_image();
        for (int k = 0; k < 5; k++) read_pixel(RIDX_W'(k));
        read_pixel(RIDX_W'(5));
        read_pixel(RIDX_W'(4095));
    endtask

    // spans where the scaled value lands exactly on a half
    task automatic test_rounding_ties();
        load_pixel(8'd20, 1'b0);
        load_pixel(8'd21, 1'b0);
        load_pixel(8'd23, 1'b0);
        load_pixel(8'd26, 1'b1);
        for (int k = 0; k < 4; k++) read_pixel(RIDX_W'(k));
        load_pixel(8'd10, 1'b0);
        load_pixel(8'd11, 1'b0);
        load_pixel(8'd12, 1'b1);
        read_pixel(RIDX_W'(1));
    endtask

    // flat images pass pixels through, single-pixel image included
    task automatic test_flat_images();
        for (int k = 0; k < 3; k++) load_pixel(8'd77, k == 2);
        for (int k = 0; k < 3; k++) read_pixel(RIDX_W'(k));
        load_pixel(8'd200, 1'b1);
        read_pixel(RIDX_W'(0));
        read_pixel(RIDX_W'(1));
    endtask

    // a load after a complete image starts over, reads fail until it completes
    task automatic test_new_image_reads();
        load_pixel(8'd90, 1'b0);
        read_pixel(RIDX_W'(0));
        load_pixel(8'd30, 1'b1);
        read_pixel(RIDX_W'(0));
        read_pixel(RIDX_W'(1));
    endtask

    // a full store drops further loads but their last mark still completes
    task automatic test_store_overflow();
        for (int k = 0; k < MAX_PIXELS; k++)
            load_pixel(PIX_W'($urandom_range(200, 40)), 1'b0);
        load_pixel(PIX_MIN, 1'b0);
        load_pixel(PIX_MAX, 1'b1);
        read_pixel(RIDX_W'(0));
        read_pixel(RIDX_W'(4095));
        for (int k = 0; k < 6; k++) read_pixel(RIDX_W'($urandom_range(4095)));
        wait_for_drain();
    endtask

    // mostly whole images with reads, some partial images and stray reads
    task automatic test_random_traffic(input int unsigned word_budget);
        int unsigned sent, npix, nreads, lo, hi, shape;
        sent = 0;
        while (sent < word_budget) begin
            shape = $urandom_range(99);
            if (shape < 80) begin
                npix = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
                lo   = $urandom_range(255);
                hi   = $urandom_range(255, lo);
                if ($urandom_range(5) == 0) begin
                    lo = 0;
                    hi = 255;
                end
                for (int k = 0; k < npix; k++)
                    load_pixel(PIX_W'($urandom_range(hi, lo)), k == npix - 1);
                nreads = $urandom_range(8, 1);
                for (int k = 0; k < nreads; k++)
                    read_pixel(($urandom_range(7) == 0) ? RIDX_W'($urandom_range(4095))
                                                        : RIDX_W'($urandom_range(npix)));
                sent += npix + nreads;
                if ($urandom_range(7) == 0) wait_for_drain();
            end else if (shape < 90) begin
                npix = $urandom_range(4, 1);
                for (int k = 0; k < npix; k++) load_pixel(PIX_W'($urandom()), 1'b0);
                read_pixel(RIDX_W'($urandom_range(npix)));
                sent += npix + 1;
            end else begin
                nreads = $urandom_range(3, 1);
                for (int k = 0; k < nreads; k++) read_pixel(RIDX_W'($urandom_range(4095)));
                sent += nreads;
            end
        end
    endtask

    // compare each result word with the oldest prediction, stall at random
    always @(posedge aclk) begin : check_results
        stretch_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (stretched_due.size() == 0) begin
                report_mismatch("result word with nothing pending, data", 0, m_tdata);
            end else begin
                due = stretched_due.pop_front();
                if (m_tdata !== due.grey) report_mismatch("pixel_out", due.grey, m_tdata);
                if (m_tuser !== due.status) report_mismatch("status", due.status, m_tuser);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 10;
        recv_stall_pct = 57;
        test_early_reads();
        test_extreme_image();
        test_rounding_ties();
        test_flat_images();
        test_new_image_reads();
        wait_for_drain();
        test_store_overflow();
        test_random_traffic(200);

        send_idle_pct  = 57;
        recv_stall_pct = 10;
        test_random_traffic(200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(200);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
